// ===== sv/binary_max_heap_queue_macros.svh =====
// Assertion macros shared by the heap queue RTL.
`ifndef BINARY_MAX_HEAP_QUEUE_MACROS_SVH
`define BINARY_MAX_HEAP_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMHQ_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BMHQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bmhq_pkg.sv =====
// Types, codes and constants of the binary max-heap queue.
`default_nettype none

package bmhq_pkg;

    localparam int KEY_W        = 32;
    localparam int INDEX_W      = 6;
    localparam int ENTRY_W      = 7;
    localparam int DEF_CAPACITY = 64;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_EXTRACT  = 2'd1,
        OP_INCREASE = 2'd2,
        OP_DELETE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FULL    = 3'd2,
        ST_SMALLER = 3'd3,
        ST_BADIDX  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST,
        S_INC,
        S_UP,
        S_UP_CMP,
        S_DOWN,
        S_DN_L,
        S_DN_R,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t                       op;
        logic signed [KEY_W-1:0]   key_value;
        logic        [INDEX_W-1:0] element_index;
    } in_t;

    typedef struct packed {
        logic signed [KEY_W-1:0]   taken_value;
        logic signed [KEY_W-1:0]   top_value;
        logic        [ENTRY_W-1:0] entries_now;
        status_t                   status;
    } out_t;

endpackage

`default_nettype wire

// ===== sv/bmhq_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/bmhq_core.sv =====
// Heap sequencer: decodes an operation and walks the sift through the key RAM.
`default_nettype none

module bmhq_core
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire in_t                         in_data,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output out_t                             res_data,
    output logic                             ram_we,
    output logic [$clog2(CAPACITY)-1:0]      ram_waddr,
    output logic [KEY_W-1:0]                 ram_wdata,
    output logic [$clog2(CAPACITY)-1:0]      ram_raddr,
    input  wire logic [KEY_W-1:0]            ram_rdata
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CHD_W  = IDX_W + 2;
    localparam int ICMP_W = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [KEY_W-1:0] root_reg, root_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [IDX_W-1:0]        hole_reg, hole_next;
    logic signed [KEY_W-1:0] best_val_reg, best_val_next;
    logic                    best_left_reg, best_left_next;
    logic signed [KEY_W-1:0] taken_reg, taken_next;
    status_t                 status_reg, status_next;
    logic                    moved_reg, moved_next;
    logic                    try_down_reg, try_down_next;

    logic [CNT_W-1:0]        cnt_dec;
    logic [CHD_W-1:0]        count_ext;
    logic [CHD_W-1:0]        left_idx;
    logic [CHD_W-1:0]        right_idx;
    logic [IDX_W-1:0]        parent_idx;
    logic [IDX_W-1:0]        in_addr;
    logic                    idx_bad;
    logic                    idx_last;
    logic signed [KEY_W-1:0] rd_key;

    // Index arithmetic of the implicit tree.
    assign cnt_dec    = count_reg - CNT_W'(1);
    assign count_ext  = CHD_W'(count_reg);
    assign left_idx   = {1'b0, hole_reg, 1'b1};
    assign right_idx  = left_idx + CHD_W'(1);
    assign parent_idx = IDX_W'((hole_reg - IDX_W'(1)) >> 1);
    assign in_addr    = in_data.element_index[IDX_W-1:0];
    assign idx_bad    = ICMP_W'(in_data.element_index) >= ICMP_W'(count_reg);
    assign idx_last   = ICMP_W'(in_data.element_index) == ICMP_W'(cnt_dec);
    assign rd_key     = $signed(ram_rdata);

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers of the current operation.
    always_ff @(posedge aclk) begin
        root_reg      <= root_next;
        key_reg       <= key_next;
        hole_reg      <= hole_next;
        best_val_reg  <= best_val_next;
        best_left_reg <= best_left_next;
        taken_reg     <= taken_next;
        status_reg    <= status_next;
        moved_reg     <= moved_next;
        try_down_reg  <= try_down_next;
    end

    // Next state, RAM accesses and result.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        hole_next      = hole_reg;
        best_val_next  = best_val_reg;
        best_left_next = best_left_reg;
        taken_next     = taken_reg;
        status_next    = status_reg;
        moved_next     = moved_reg;
        try_down_next  = try_down_reg;
        ram_we         = 1'b0;
        ram_waddr      = hole_reg;
        ram_wdata      = key_reg;
        ram_raddr      = '0;
        in_ready       = 1'b0;
        res_valid      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    taken_next  = '0;
                    status_next = ST_OK;
                    moved_next  = 1'b0;
                    key_next    = in_data.key_value;
                    unique case (in_data.op)
                        OP_INSERT: begin
                            if (count_reg == CNT_W'(CAPACITY)) begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end else begin
                                hole_next     = IDX_W'(count_reg);
                                count_next    = count_reg + CNT_W'(1);
                                try_down_next = 1'b0;
                                state_next    = S_UP;
                            end
                        end
                        OP_EXTRACT: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end else begin
                                taken_next = root_reg;
                                count_next = cnt_dec;
                                if (cnt_dec == '0) begin
                                    state_next = S_DONE;
                                end else begin
                                    ram_raddr     = IDX_W'(cnt_dec);
                                    hole_next     = '0;
                                    try_down_next = 1'b1;
                                    state_next    = S_LAST;
                                end
                            end
                        end
                        OP_INCREASE: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end else if (idx_bad) begin
                                status_next = ST_BADIDX;
                                state_next  = S_DONE;
                            end else begin
                                ram_raddr     = in_addr;
                                hole_next     = in_addr;
                                try_down_next = 1'b0;
                                state_next    = S_INC;
                            end
                        end
                        OP_DELETE: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end else if (idx_bad) begin
                                status_next = ST_BADIDX;
                                state_next  = S_DONE;
                            end else begin
                                count_next = cnt_dec;
                                if (idx_last) begin
                                    state_next = S_DONE;
                                end else begin
                                    ram_raddr     = IDX_W'(cnt_dec);
                                    hole_next     = in_addr;
                                    try_down_next = 1'b1;
                                    state_next    = S_LAST;
                                end
                            end
                        end
                    endcase
                end
            end

            // The last entry becomes the key that moves into the hole.
            S_LAST: begin
                key_next   = rd_key;
                state_next = S_UP;
            end

            // An increase never lowers a key.
            S_INC: begin
                if (rd_key > key_reg) begin
                    status_next = ST_SMALLER;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_UP;
                end
            end

            // Fetch the parent of the hole, or settle at the root.
            S_UP: begin
                if (hole_reg == '0) begin
                    if (try_down_reg && !moved_reg) begin
                        state_next = S_DOWN;
                    end else begin
                        ram_we     = 1'b1;
                        state_next = S_DONE;
                    end
                end else begin
                    ram_raddr  = parent_idx;
                    state_next = S_UP_CMP;
                end
            end

            // A smaller parent drops into the hole and the hole climbs.
            S_UP_CMP: begin
                if (key_reg > rd_key) begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    hole_next  = parent_idx;
                    moved_next = 1'b1;
                    state_next = S_UP;
                end else if (try_down_reg && !moved_reg) begin
                    state_next = S_DOWN;
                end else begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
            end

            // Fetch the left child, or settle when the hole is a leaf.
            S_DOWN: begin
                if (left_idx >= count_ext) begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end else begin
                    ram_raddr  = left_idx[IDX_W-1:0];
                    state_next = S_DN_L;
                end
            end

            // Compare the left child; fetch the right child if there is one.
            S_DN_L: begin
                if (right_idx < count_ext) begin
                    best_left_next = rd_key > key_reg;
                    best_val_next  = (rd_key > key_reg) ? rd_key : key_reg;
                    ram_raddr      = right_idx[IDX_W-1:0];
                    state_next     = S_DN_R;
                end else if (rd_key > key_reg) begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    hole_next  = left_idx[IDX_W-1:0];
                    state_next = S_DOWN;
                end else begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
            end

            // The right child wins only if strictly larger than the best so far.
            S_DN_R: begin
                ram_we = 1'b1;
                if (rd_key > best_val_reg) begin
                    ram_wdata  = ram_rdata;
                    hole_next  = right_idx[IDX_W-1:0];
                    state_next = S_DOWN;
                end else if (best_left_reg) begin
                    ram_wdata  = best_val_reg;
                    hole_next  = left_idx[IDX_W-1:0];
                    state_next = S_DOWN;
                end else begin
                    state_next = S_DONE;
                end
            end

            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Slot zero is mirrored so the maximum is known without a read.
        root_next = (ram_we && ram_waddr == '0) ? $signed(ram_wdata) : root_reg;
    end

    // Result of the finished operation.
    always_comb begin
        res_data.taken_value = taken_reg;
        res_data.top_value   = (count_reg != '0) ? root_reg : '0;
        res_data.entries_now = ENTRY_W'(count_reg);
        res_data.status      = status_reg;
    end

endmodule

`default_nettype wire

// ===== sv/binary_max_heap_queue.sv =====
// Binary max-heap priority queue top level with its output register.
//
// The queue holds up to CAPACITY (2 to 64) signed 32-bit keys in one RAM laid
// out as an implicit binary tree, slot 0 being the maximum. Each transfer on
// the s_ channel carries one operation (insert, extract maximum, increase key
// at a slot, delete at a slot) and yields exactly one transfer on the m_
// channel with the extracted key, the new maximum, the entry count and a
// status. One operation is worked at a time. A sift costs one RAM
// read-compare step per tree level: an upward sift fetches the parent and
// compares it, a downward sift fetches the left child, then the right child,
// then moves. The result register lets the next operation start while a
// result waits on m_ready. Reads of the RAM are registered.
`default_nettype none
`include "binary_max_heap_queue_macros.svh"

module binary_max_heap_queue
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic             res_valid;
    logic             res_ready;
    out_t             res_data;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [KEY_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [KEY_W-1:0] ram_rdata;
    logic             out_valid_reg;
    out_t             out_data_reg;

    // Key store.
    bmhq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Operation sequencer.
    bmhq_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Output register: loads when empty or when its result is being taken.
    assign res_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_data_reg <= res_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Checks on the sequencer's results and the output register.
    `BMHQ_ASSERT_IMPL(a_count_bound, aclk, aresetn, res_valid,
        res_data.entries_now <= ENTRY_W'(CAPACITY), "entry count beyond capacity")
    `BMHQ_ASSERT_IMPL(a_empty_clean, aclk, aresetn, res_valid && res_data.status == ST_EMPTY,
        res_data.entries_now == '0 && res_data.taken_value == '0,
        "empty status with keys or a taken key")
    `BMHQ_ASSERT_IMPL(a_full_count, aclk, aresetn, res_valid && res_data.status == ST_FULL,
        res_data.entries_now == ENTRY_W'(CAPACITY), "full status below capacity")
    `BMHQ_ASSERT_NEXT(a_res_lands, aclk, aresetn, res_valid && res_ready,
        out_valid_reg && out_data_reg == $past(res_data),
        "result lost on the way to the output register")

endmodule

`default_nettype wire
